>>> src/jkv_pkg.sv
// ----------------------------------------------------------------------------
// jkv_pkg
// shared types and constants of the json key/value extractor
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int DATA_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int INT_W      = 31;
    localparam int ACC_W      = 30;
    localparam int CNT_W      = 5;
    localparam int PIDX_W     = 5;
    localparam int PAT_BYTES  = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_MID    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_HIGH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_MODE     = 3'd4;

    localparam logic [DATA_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [DATA_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [DATA_W-1:0] CH_BRACE  = 8'h7D;
    localparam logic [DATA_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [DATA_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [DATA_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [DATA_W-1:0] CH_TAB    = 8'h09;
    localparam logic [DATA_W-1:0] CH_CR     = 8'h0D;
    localparam logic [DATA_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE   = 8'h39;

    localparam logic [INT_W-1:0] INT_NONE = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INT_VALUE = 2'd0,
        ST_TEXT_BYTE = 2'd1,
        ST_TEXT_END  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        NUM_BLANKS = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_STOP   = 2'd2
    } num_phase_t;

endpackage

>>> src/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor
// finds a configured key in a byte stream and returns its integer or string
// value
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata = data_byte, tuser = first_byte,
//                                  tlast = last_byte
// m_*      out  tvalid/tready      tdata = int_value, text_byte, truncated,
//                                  tuser = status
// cfg_*    in   cfg_we             cfg_addr register index, cfg_data value
//
// one item per cycle sustained while m_tready is high: input register, one pass
// of match and convert logic, result register, in that order from accept to result
// the per-item path is the key compare and the multiply-by-ten accumulate
// rst_n clears all control state and sets pattern_length to one
// a stalled result holds the input register; one more item is held there
// ----------------------------------------------------------------------------
module json_key_value_extractor #(
    parameter int MAX_PATTERN      = 24,
    parameter int MAX_INT_CHARS    = 9,
    parameter int MAX_STRING_CHARS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jkv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [jkv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jkv_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                               s_tuser,   // [0] first_byte
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [jkv_pkg::M_TDATA_W-1:0]      m_tdata,   // [30:0] int_value,
                                                          // [38:31] text_byte,
                                                          // [39] truncated
    output logic [jkv_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
    import jkv_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] pattern_low_reg, pattern_mid_reg, pattern_high_reg;
    logic [PIDX_W-1:0]     pattern_length_reg;
    logic                  value_mode_reg;

    // input register
    logic                  in_valid_reg;
    logic [DATA_W-1:0]     in_byte_reg;
    logic                  in_first_reg;
    logic                  in_last_reg;

    // search state
    logic [PIDX_W-1:0]     match_index_reg, match_index_next;
    logic                  key_found_reg, key_found_next;
    logic                  finished_reg, finished_next;
    num_phase_t            num_phase_reg, num_phase_next;
    logic                  negative_reg, negative_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  dropped_reg, dropped_next;

    // result register
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [INT_W-1:0]      out_int_reg;
    logic [DATA_W-1:0]     out_text_reg;
    logic                  out_trunc_reg;

    // per-item logic
    logic                  advance;
    logic                  res_valid;
    status_t               res_status;
    logic [INT_W-1:0]      res_int;
    logic [DATA_W-1:0]     res_text;
    logic                  res_trunc;
    logic [PIDX_W-1:0]     eff_match;
    logic                  eff_key_found, eff_finished, eff_negative, eff_dropped;
    num_phase_t            eff_phase;
    logic [ACC_W-1:0]      eff_acc;
    logic [CNT_W-1:0]      eff_count;
    logic [PIDX_W-1:0]     used_len;
    logic [PIDX_W-1:0]     match_inc;
    logic [3*CFG_DATA_W-1:0] pattern_all;
    logic [DATA_W-1:0]     pat_byte;
    logic                  is_digit, is_blank, is_term;
    logic [INT_W-1:0]      acc_ext;
    logic [ACC_W-1:0]      acc_times_ten;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_trunc_reg, out_text_reg, out_int_reg};
    assign m_tuser  = out_status_reg;

    assign pattern_all = {pattern_high_reg, pattern_mid_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_len = PIDX_W'(1);
        end
        else if (pattern_length_reg > PIDX_W'(MAX_PATTERN))
        begin
            used_len = PIDX_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = pattern_length_reg;
        end
    end

    // first_byte clears the state before the byte is used
    assign eff_match     = in_first_reg ? '0 : match_index_reg;
    assign eff_key_found = in_first_reg ? 1'b0 : key_found_reg;
    assign eff_finished  = in_first_reg ? 1'b0 : finished_reg;
    assign eff_phase     = in_first_reg ? NUM_BLANKS : num_phase_reg;
    assign eff_negative  = in_first_reg ? 1'b0 : negative_reg;
    assign eff_acc       = in_first_reg ? '0 : acc_reg;
    assign eff_count     = in_first_reg ? '0 : count_reg;
    assign eff_dropped   = in_first_reg ? 1'b0 : dropped_reg;

    assign pat_byte  = pattern_all[{eff_match, 3'b000} +: DATA_W];
    assign match_inc = eff_match + PIDX_W'(1);

    assign is_digit = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign is_blank = (in_byte_reg == CH_SPACE)
                   || ((in_byte_reg >= CH_TAB) && (in_byte_reg <= CH_CR));
    assign is_term  = (in_byte_reg == CH_QUOTE) || (in_byte_reg == CH_COMMA)
                   || (in_byte_reg == CH_BRACE);

    assign acc_ext       = {1'b0, eff_acc};
    assign acc_times_ten = {eff_acc[ACC_W-4:0], 3'b000} + {eff_acc[ACC_W-2:0], 1'b0}
                         + ACC_W'(in_byte_reg[3:0]);

    always_comb
    begin
        match_index_next = eff_match;
        key_found_next   = eff_key_found;
        finished_next    = eff_finished;
        num_phase_next   = eff_phase;
        negative_next    = eff_negative;
        acc_next         = eff_acc;
        count_next       = eff_count;
        dropped_next     = eff_dropped;
        res_valid        = 1'b0;
        res_status       = ST_NOT_FOUND;
        res_int          = INT_NONE;
        res_text         = '0;
        res_trunc        = 1'b0;

        if (!eff_finished)
        begin
            if (!eff_key_found)
            begin
                if (in_byte_reg == pat_byte)
                begin
                    if (match_inc >= used_len)
                    begin
                        match_index_next = '0;
                        key_found_next   = 1'b1;
                    end
                    else
                    begin
                        match_index_next = match_inc;
                    end
                end
                else
                begin
                    match_index_next = '0;
                end
            end
            else if (!value_mode_reg)
            begin
                if (is_term)
                begin
                    finished_next = 1'b1;
                    res_valid     = 1'b1;
                    res_status    = ST_INT_VALUE;
                    res_int       = eff_negative ? (~acc_ext + INT_W'(1)) : acc_ext;
                end
                else if (eff_count < CNT_W'(MAX_INT_CHARS))
                begin
                    count_next = eff_count + CNT_W'(1);
                    case (eff_phase)
                        NUM_BLANKS:
                        begin
                            if (is_blank)
                            begin
                                num_phase_next = NUM_BLANKS;
                            end
                            else if (in_byte_reg == CH_PLUS)
                            begin
                                num_phase_next = NUM_DIGITS;
                            end
                            else if (in_byte_reg == CH_MINUS)
                            begin
                                negative_next  = 1'b1;
                                num_phase_next = NUM_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next       = ACC_W'(in_byte_reg[3:0]);
                                num_phase_next = NUM_DIGITS;
                            end
                            else
                            begin
                                num_phase_next = NUM_STOP;
                            end
                        end
                        NUM_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_times_ten;
                            end
                            else
                            begin
                                num_phase_next = NUM_STOP;
                            end
                        end
                        default:
                        begin
                            num_phase_next = eff_phase;
                        end
                    endcase
                end
            end
            else
            begin
                if (in_byte_reg == CH_QUOTE)
                begin
                    finished_next = 1'b1;
                    res_valid     = 1'b1;
                    res_status    = ST_TEXT_END;
                    res_trunc     = eff_dropped;
                end
                else if (eff_count < CNT_W'(MAX_STRING_CHARS))
                begin
                    count_next = eff_count + CNT_W'(1);
                    if (!in_last_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TEXT_BYTE;
                        res_text   = in_byte_reg;
                    end
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end

            // last byte with no value yet
            if (in_last_reg && !finished_next)
            begin
                finished_next = 1'b1;
                res_valid     = 1'b1;
                res_status    = ST_NOT_FOUND;
                res_int       = INT_NONE;
                res_text      = '0;
                res_trunc     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_mid_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= PIDX_W'(1);
            value_mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_MID:    pattern_mid_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PIDX_W-1:0];
                CFG_VALUE_MODE:     value_mode_reg     <= cfg_data[0];
                default:            value_mode_reg     <= value_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_index_reg <= '0;
            key_found_reg   <= 1'b0;
            finished_reg    <= 1'b0;
            num_phase_reg   <= NUM_BLANKS;
            negative_reg    <= 1'b0;
            acc_reg         <= '0;
            count_reg       <= '0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                match_index_reg <= match_index_next;
                key_found_reg   <= key_found_next;
                finished_reg    <= finished_next;
                num_phase_reg   <= num_phase_next;
                negative_reg    <= negative_next;
                acc_reg         <= acc_next;
                count_reg       <= count_next;
                dropped_reg     <= dropped_next;
                out_valid_reg   <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= res_status;
            out_int_reg    <= res_int;
            out_text_reg   <= res_text;
            out_trunc_reg  <= res_trunc;
        end
    end

`ifndef SYNTHESIS
    a_final_result_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res_status != ST_TEXT_BYTE) |=> finished_reg)
        else $error("final result did not stop the search");

    a_match_cleared_on_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_found_reg |-> (match_index_reg == '0))
        else $error("match index not cleared after key found");

    a_phase_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (num_phase_reg != NUM_BLANKS || count_reg != '0) |-> key_found_reg)
        else $error("value state moved before the key was found");

    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        match_index_reg < PIDX_W'(MAX_PATTERN))
        else $error("match index beyond pattern");
`endif

endmodule
